>>> rtl/gzs_pkg.sv
// shared types, constants and helpers of the gzip header stripper
package gzs_pkg;

	// parser phases, in stream order
	typedef enum logic [3:0] {
		PH_MAGIC0  = 4'd0,
		PH_MAGIC1  = 4'd1,
		PH_PASS    = 4'd2,
		PH_FIXED   = 4'd3,
		PH_XLEN0   = 4'd4,
		PH_XLEN1   = 4'd5,
		PH_XDATA   = 4'd6,
		PH_NAME    = 4'd7,
		PH_COMMENT = 4'd8,
		PH_CRC     = 4'd9,
		PH_PAYLOAD = 4'd10,
		PH_DISCARD = 4'd11
	} phase_t;

	// status codes
	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_INVALID   = 3'd1;
	localparam logic [2:0] ERR_XLEN      = 3'd2;
	localparam logic [2:0] ERR_XDATA     = 3'd3;
	localparam logic [2:0] ERR_NAME      = 3'd4;
	localparam logic [2:0] ERR_COMMENT   = 3'd5;
	localparam logic [2:0] ERR_TRUNCATED = 3'd6;

	// result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// header constants
	localparam logic [7:0] MAGIC_ID1      = 8'h1F;
	localparam logic [7:0] MAGIC_ID2      = 8'h8B;
	localparam logic [7:0] METHOD_DEFLATE = 8'h08;
	localparam logic [7:0] FLG_EXTRA      = 8'h04;
	localparam logic [7:0] FLG_NAME       = 8'h08;
	localparam logic [7:0] FLG_COMMENT    = 8'h10;
	localparam logic [7:0] FLG_HCRC       = 8'h02;
	localparam logic [3:0] HDR_METHOD_IDX = 4'd2;
	localparam logic [3:0] HDR_FLAGS_IDX  = 4'd3;
	localparam logic [3:0] HDR_LAST_IDX   = 4'd9;
	localparam logic [4:0] MIN_TOTAL      = 5'd18;

	// trailer delay line
	localparam int DELAY_DEPTH = 8;
	localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
	localparam int DELAY_CW    = $clog2(DELAY_DEPTH + 1);

	// bundle queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// results per input transaction
	localparam int MAX_RESULTS = 3;
	localparam int RES_CW      = $clog2(MAX_RESULTS + 1);
	localparam int RES_IW      = $clog2(MAX_RESULTS);

	typedef struct packed {
		logic [7:0] data;
		logic       kind;
		logic [2:0] err;
		logic       gz;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [RES_CW-1:0]            count;
		result_t [MAX_RESULTS-1:0]    recs;
	} bundle_t;

	function automatic result_t mk_result(input logic [7:0] data, input logic kind,
			input logic [2:0] err, input logic gz);
		result_t r;
		r.data = data;
		r.kind = kind;
		r.err  = err;
		r.gz   = gz;
		r.last = 1'b0;
		return r;
	endfunction

	// next optional header section starting at stage k (0 extra, 1 name, 2 comment, 3 crc)
	function automatic phase_t section_after(input logic [1:0] k, input logic [7:0] flg);
		phase_t p;
		if (k <= 2'd0 && (flg & FLG_EXTRA) != 8'h00) begin
			p = PH_XLEN0;
		end else if (k <= 2'd1 && (flg & FLG_NAME) != 8'h00) begin
			p = PH_NAME;
		end else if (k <= 2'd2 && (flg & FLG_COMMENT) != 8'h00) begin
			p = PH_COMMENT;
		end else if ((flg & FLG_HCRC) != 8'h00) begin
			p = PH_CRC;
		end else begin
			p = PH_PAYLOAD;
		end
		return p;
	endfunction

endpackage

>>> rtl/gzs_front.sv
// front end: header parser, trailer delay line and result bundling
module gzs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         in_byte,
	input  logic               end_of_stream,
	output logic               push,
	output gzs_pkg::bundle_t   push_bundle
);

	localparam logic [gzs_pkg::RES_CW-1:0] RES_ONE = gzs_pkg::RES_CW'(1);
	localparam logic [gzs_pkg::RES_CW-1:0] RES_TWO = gzs_pkg::RES_CW'(2);

	gzs_pkg::phase_t                 phase_q, phase_n;
	logic [3:0]                      hidx_q, hidx_n;
	logic [15:0]                     skip_q, skip_n;
	logic [7:0]                      flags_q, flags_n;
	logic [7:0]                      held_q, held_n;
	logic [gzs_pkg::DELAY_CW-1:0]    fill_q, fill_n;
	logic [4:0]                      total_q, total_n;
	logic                            sticky_q, sticky_n;
	logic [7:0]                      delay_q [gzs_pkg::DELAY_DEPTH];
	logic                            dl_write, dl_shift;
	logic [gzs_pkg::RES_CW-1:0]      n_data, n_total;
	logic [2:0]                      st_err;
	logic                            st_gz;
	gzs_pkg::bundle_t                bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= gzs_pkg::PH_MAGIC0;
			hidx_q   <= '0;
			skip_q   <= '0;
			flags_q  <= '0;
			held_q   <= '0;
			fill_q   <= '0;
			total_q  <= '0;
			sticky_q <= 1'b0;
		end else if (accept) begin
			phase_q  <= end_of_stream ? gzs_pkg::PH_MAGIC0 : phase_n;
			hidx_q   <= end_of_stream ? '0 : hidx_n;
			skip_q   <= end_of_stream ? '0 : skip_n;
			flags_q  <= end_of_stream ? '0 : flags_n;
			held_q   <= end_of_stream ? '0 : held_n;
			fill_q   <= end_of_stream ? '0 : fill_n;
			total_q  <= end_of_stream ? '0 : total_n;
			sticky_q <= end_of_stream ? 1'b0 : sticky_n;
		end
	end

	// trailer delay line, read only at its head
	always_ff @(posedge clk) begin
		if (accept && dl_write) begin
			delay_q[fill_q[gzs_pkg::DELAY_AW-1:0]] <= in_byte;
		end else if (accept && dl_shift) begin
			for (int i = 0; i < gzs_pkg::DELAY_DEPTH - 1; i++) begin
				delay_q[i] <= delay_q[i+1];
			end
			delay_q[gzs_pkg::DELAY_DEPTH-1] <= in_byte;
		end
	end

	always_comb begin
		phase_n  = phase_q;
		hidx_n   = hidx_q;
		skip_n   = skip_q;
		flags_n  = flags_q;
		held_n   = held_q;
		fill_n   = fill_q;
		sticky_n = sticky_q;
		total_n  = (total_q < gzs_pkg::MIN_TOTAL) ? 5'(total_q + 5'd1) : total_q;
		dl_write = 1'b0;
		dl_shift = 1'b0;
		n_data   = '0;
		bnd      = '0;

		unique case (phase_q)
			gzs_pkg::PH_MAGIC0: begin
				bnd.recs[0] = gzs_pkg::mk_result(in_byte, gzs_pkg::KIND_DATA,
					gzs_pkg::ERR_OK, 1'b0);
				if (in_byte == gzs_pkg::MAGIC_ID1) begin
					held_n  = in_byte;
					phase_n = gzs_pkg::PH_MAGIC1;
					if (end_of_stream) begin
						n_data = RES_ONE;
					end
				end else begin
					n_data  = RES_ONE;
					phase_n = gzs_pkg::PH_PASS;
				end
			end
			gzs_pkg::PH_MAGIC1: begin
				if (in_byte == gzs_pkg::MAGIC_ID2) begin
					phase_n = gzs_pkg::PH_FIXED;
					hidx_n  = gzs_pkg::HDR_METHOD_IDX;
				end else begin
					bnd.recs[0] = gzs_pkg::mk_result(held_q, gzs_pkg::KIND_DATA,
						gzs_pkg::ERR_OK, 1'b0);
					bnd.recs[1] = gzs_pkg::mk_result(in_byte, gzs_pkg::KIND_DATA,
						gzs_pkg::ERR_OK, 1'b0);
					n_data  = RES_TWO;
					phase_n = gzs_pkg::PH_PASS;
				end
			end
			gzs_pkg::PH_PASS: begin
				bnd.recs[0] = gzs_pkg::mk_result(in_byte, gzs_pkg::KIND_DATA,
					gzs_pkg::ERR_OK, 1'b0);
				n_data = RES_ONE;
			end
			gzs_pkg::PH_FIXED: begin
				if (hidx_q == gzs_pkg::HDR_METHOD_IDX && in_byte != gzs_pkg::METHOD_DEFLATE) begin
					sticky_n = 1'b1;
					phase_n  = gzs_pkg::PH_DISCARD;
				end else begin
					if (hidx_q == gzs_pkg::HDR_FLAGS_IDX) begin
						flags_n = in_byte;
					end
					if (hidx_q >= gzs_pkg::HDR_LAST_IDX) begin
						phase_n = gzs_pkg::section_after(2'd0, flags_q);
					end else begin
						hidx_n = 4'(hidx_q + 4'd1);
					end
				end
			end
			gzs_pkg::PH_XLEN0: begin
				skip_n  = {8'h00, in_byte};
				phase_n = gzs_pkg::PH_XLEN1;
			end
			gzs_pkg::PH_XLEN1: begin
				skip_n  = {in_byte, skip_q[7:0]};
				phase_n = (skip_n != 16'd0) ? gzs_pkg::PH_XDATA
					: gzs_pkg::section_after(2'd1, flags_q);
			end
			gzs_pkg::PH_XDATA: begin
				skip_n = 16'(skip_q - 16'd1);
				if (skip_n == 16'd0) begin
					phase_n = gzs_pkg::section_after(2'd1, flags_q);
				end
			end
			gzs_pkg::PH_NAME: begin
				if (in_byte == 8'h00) begin
					phase_n = gzs_pkg::section_after(2'd2, flags_q);
				end
			end
			gzs_pkg::PH_COMMENT: begin
				if (in_byte == 8'h00) begin
					phase_n = gzs_pkg::section_after(2'd3, flags_q);
				end
			end
			gzs_pkg::PH_CRC: begin
				if (hidx_q == 4'd0) begin
					hidx_n = 4'd1;
				end else begin
					phase_n = gzs_pkg::PH_PAYLOAD;
				end
			end
			gzs_pkg::PH_PAYLOAD: begin
				if (fill_q < gzs_pkg::DELAY_CW'(gzs_pkg::DELAY_DEPTH)) begin
					dl_write = 1'b1;
					fill_n   = gzs_pkg::DELAY_CW'(fill_q + 1'b1);
				end else begin
					dl_shift    = 1'b1;
					bnd.recs[0] = gzs_pkg::mk_result(delay_q[0], gzs_pkg::KIND_DATA,
						gzs_pkg::ERR_OK, 1'b1);
					n_data      = RES_ONE;
				end
			end
			gzs_pkg::PH_DISCARD: begin
			end
			default: begin
			end
		endcase

		// the header crc counts its two bytes from zero
		if (phase_n == gzs_pkg::PH_CRC && phase_q != gzs_pkg::PH_CRC) begin
			hidx_n = 4'd0;
		end

		// end-of-stream status from the state after this byte
		st_gz  = (phase_n >= gzs_pkg::PH_FIXED);
		st_err = gzs_pkg::ERR_OK;
		if (st_gz) begin
			if (total_n < gzs_pkg::MIN_TOTAL || sticky_n) begin
				st_err = gzs_pkg::ERR_INVALID;
			end else begin
				case (phase_n) inside
					gzs_pkg::PH_XLEN0, gzs_pkg::PH_XLEN1: st_err = gzs_pkg::ERR_XLEN;
					gzs_pkg::PH_XDATA:   st_err = gzs_pkg::ERR_XDATA;
					gzs_pkg::PH_NAME:    st_err = gzs_pkg::ERR_NAME;
					gzs_pkg::PH_COMMENT: st_err = gzs_pkg::ERR_COMMENT;
					gzs_pkg::PH_CRC:     st_err = gzs_pkg::ERR_TRUNCATED;
					gzs_pkg::PH_PAYLOAD: begin
						st_err = (fill_n < gzs_pkg::DELAY_CW'(gzs_pkg::DELAY_DEPTH))
							? gzs_pkg::ERR_TRUNCATED : gzs_pkg::ERR_OK;
					end
					default: st_err = gzs_pkg::ERR_INVALID;
				endcase
			end
		end

		n_total = n_data;
		if (end_of_stream) begin
			bnd.recs[n_data[gzs_pkg::RES_IW-1:0]] = gzs_pkg::mk_result(8'h00,
				gzs_pkg::KIND_STATUS, st_err, st_gz);
			n_total = gzs_pkg::RES_CW'(n_data + 1'b1);
		end

		// mark the final result of this transaction
		if (n_total != '0) begin
			bnd.recs[gzs_pkg::RES_IW'(n_total - 1'b1)].last = 1'b1;
		end
		bnd.count = n_total;
	end

	assign push        = accept && (n_total != '0);
	assign push_bundle = bnd;

endmodule

>>> rtl/gzs_queue.sv
// short queue of result bundles between the parser and the output side
module gzs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gzs_pkg::bundle_t   push_bundle,
	input  logic               pop,
	output logic               full,
	output logic               head_valid,
	output gzs_pkg::bundle_t   head_bundle
);

	gzs_pkg::bundle_t                mem_q [gzs_pkg::QUEUE_DEPTH];
	logic [gzs_pkg::QUEUE_AW-1:0]    wptr_q, rptr_q;
	logic [gzs_pkg::QUEUE_CW-1:0]    count_q;
	logic                            do_push, do_pop;

	assign do_push = push && !full;
	assign do_pop  = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= gzs_pkg::QUEUE_AW'(wptr_q + 1'b1);
			end
			if (do_pop) begin
				rptr_q <= gzs_pkg::QUEUE_AW'(rptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= gzs_pkg::QUEUE_CW'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= gzs_pkg::QUEUE_CW'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_bundle;
		end
	end

	assign full        = (count_q == gzs_pkg::QUEUE_CW'(gzs_pkg::QUEUE_DEPTH));
	assign head_valid  = (count_q != '0);
	assign head_bundle = mem_q[rptr_q];

endmodule

>>> rtl/gzs_back.sv
// back end: unpacks bundles into single results behind an output register
module gzs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  gzs_pkg::bundle_t   head_bundle,
	output logic               pop,
	input  logic               result_stall,
	output logic               result_valid,
	output gzs_pkg::result_t   result
);

	logic [gzs_pkg::RES_IW-1:0]  idx_q;
	logic                        valid_q;
	gzs_pkg::result_t            res_q;
	logic                        load, take, last_rec;

	assign load     = !valid_q || !result_stall;
	assign take     = load && head_valid;
	assign last_rec = (gzs_pkg::RES_CW'(idx_q) + 1'b1) == head_bundle.count;
	assign pop      = take && last_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= head_valid;
			if (take) begin
				idx_q <= last_rec ? '0 : gzs_pkg::RES_IW'(idx_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= head_bundle.recs[idx_q];
		end
	end

	assign result_valid = valid_q;
	assign result       = res_q;

endmodule

>>> rtl/gzip_header_stripper.sv
// top level of the gzip header stripper
// Takes a response one byte per transaction and strips a gzip wrapper from it: a
// stream that opens with 1F 8B and method 08 has its fixed header, optional extra
// field, name, comment and header crc skipped, its deflate payload forwarded, and
// its 8-byte trailer held back in a delay line and dropped; after another method
// byte the rest is dropped, and any other stream passes through unchanged. The
// transaction marked end_of_stream also yields one status result (item_kind 1)
// carrying error_code and gzip_seen, and last_of_run flags the final result of
// each input transaction. The block sustains one input byte per cycle while each
// byte yields at most one result: the front parser takes a byte every cycle unless
// its four-entry bundle queue is full, and the back side hands out one result per
// cycle from its output register unless result_stall holds it. The byte that ends
// a stream yields one more result (the status), and a failed magic match at the
// end of a stream yields three; the queue absorbs such bursts and repays them
// during header bytes and the first eight payload bytes, which yield none, while a
// long run of them holds the input to the output rate of one result per cycle. The
// first result of a transaction goes through the queue and the output register.
module gzip_header_stripper (
	input  logic        clk,
	input  logic        arst_n,
	// input byte channel
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_stream,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  out_byte,
	output logic        item_kind,
	output logic [2:0]  error_code,
	output logic        gzip_seen,
	output logic        last_of_run
);

	logic               accept;
	logic               push, pop, full, head_valid;
	gzs_pkg::bundle_t   push_bundle, head_bundle;
	gzs_pkg::result_t   result;

	// a full queue holds off the upstream side
	assign byte_stall = full;
	assign accept     = byte_valid && !byte_stall;

	// parse and classify every accepted transaction into a bundle of results
	gzs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.push          (push),
		.push_bundle   (push_bundle)
	);

	// decouples the parser from downstream stalls
	gzs_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_bundle (push_bundle),
		.pop         (pop),
		.full        (full),
		.head_valid  (head_valid),
		.head_bundle (head_bundle)
	);

	// unpacks each bundle into single results on the output side
	gzs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_bundle  (head_bundle),
		.pop          (pop),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

	assign out_byte    = result.data;
	assign item_kind   = result.kind;
	assign error_code  = result.err;
	assign gzip_seen   = result.gz;
	assign last_of_run = result.last;

endmodule

>>> rtl/gzs_checker.sv
// port-level checks of the gzip header stripper, bound to the top level
module gzs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_stream,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [7:0]  out_byte,
	input  logic        item_kind,
	input  logic [2:0]  error_code,
	input  logic        gzip_seen,
	input  logic        last_of_run
);

	// a stalled result transaction holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_byte)
			&& $stable(item_kind) && $stable(error_code) && $stable(last_of_run))
		else $error("stalled result changed");

	// a status result carries no byte and closes its run
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_kind == gzs_pkg::KIND_STATUS |-> out_byte == 8'h00 && last_of_run)
		else $error("malformed status result");

	// data results never carry an error
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_kind == gzs_pkg::KIND_DATA |-> error_code == gzs_pkg::ERR_OK)
		else $error("data result with error code");

	// a non-gzip status is always ok
	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_kind == gzs_pkg::KIND_STATUS && !gzip_seen
			|-> error_code == gzs_pkg::ERR_OK)
		else $error("pass-through stream reported an error");

endmodule

bind gzip_header_stripper gzs_checker u_gzs_checker (.*);
